// ===== src/humidity_temp_frame_decoder_core_macros.svh =====
// assertion macros shared by the frame decoder modules
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off while in reset
`define HFTD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hftd: assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define HFTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hftd: assertion failed");

`else

`define HFTD_ASSERT_NOW(lbl, ante, cons)
`define HFTD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== src/hftd_pkg.sv =====
// shared types, constants and the crc-8 step for the frame decoder
// no dependencies
package hftd_pkg;

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    localparam logic [14:0] TEMP_SCALE  = 15'd21875;
    localparam logic [13:0] HUMID_SCALE = 14'd12500;
    localparam logic [15:0] TEMP_OFFSET = 16'd45000;
    localparam int          FRAC_BITS   = 13;

    localparam int          HFTD_FIFO_DEPTH = 4;

    // result status codes
    localparam logic [1:0]  ST_OK        = 2'd0;
    localparam logic [1:0]  ST_TEMP_CRC  = 2'd1;
    localparam logic [1:0]  ST_HUMID_CRC = 2'd2;

    // one checked frame, as queued between front and back
    typedef struct packed {
        logic [15:0] temp_word;
        logic [15:0] humid_word;
        logic [1:0]  status;
    } hftd_frame_t;

    // push request from the front end
    typedef struct packed {
        logic        valid;
        hftd_frame_t frame;
    } hftd_push_t;

    // queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } hftd_qstat_t;

    // one byte through crc-8, msb first
    function automatic logic [7:0] hftd_crc8(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/humidity_temp_frame_decoder_core.sv =====
// top level of the humidity and temperature frame decoder
// depends on hftd_pkg, hftd_front, hftd_fifo and hftd_back
//
// usage
//  - input channel: one response byte per request (resp_byte), with
//    frame_start high on the first byte of a frame; taken on any edge with
//    in_valid high and in_stall low
//  - frame order: temperature msb, lsb, crc, then humidity msb, lsb, crc;
//    each word is checked with crc-8 (poly 0x31, init 0xff)
//  - output channel: one result request per sixth byte, carrying
//    temp_milli_c, humid_milli_pct and status; taken when out_valid is
//    high and out_stall is low
//  - a crc mismatch gives status 1 (temperature) or 2 (humidity), with
//    both values zero; temperature failure wins
//  - frame_start mid-frame drops the partial frame with no result
//  - throughput: one byte per cycle while in_stall is low; the crc step
//    in the front end is combinational
//  - after the edge that takes the sixth byte, the frame passes the queue
//    entry, the multiply register and the result register before out_valid rises
//  - when out_stall holds, up to FIFO_DEPTH finished frames plus two in
//    the back end wait; only then does in_stall rise
//  - reset: frame position zero, crc preset, queue empty, no result
module humidity_temp_frame_decoder_core #(
    parameter int FIFO_DEPTH = hftd_pkg::HFTD_FIFO_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         resp_byte,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [17:0] temp_milli_c,
    output logic [16:0]        humid_milli_pct,
    output logic [1:0]         status
);
    import hftd_pkg::*;

    // requests from the front end into the queue
    hftd_push_t  push;
    // queue flags seen by both sides
    hftd_qstat_t qstat;
    // head of the queue and its pop strobe
    hftd_frame_t rd_frame;
    logic        pop;

    hftd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .resp_byte   (resp_byte),
        .frame_start (frame_start),
        .qstat       (qstat),
        .push        (push)
    );

    // decouples byte intake from result delivery
    hftd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .rd_frame (rd_frame),
        .qstat    (qstat)
    );

    // scaling and the output register
    hftd_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .qstat           (qstat),
        .rd_frame        (rd_frame),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .temp_milli_c    (temp_milli_c),
        .humid_milli_pct (humid_milli_pct),
        .status          (status)
    );

endmodule

// ===== src/hftd_front.sv =====
// front end: byte position tracking, crc checking and word capture
// depends on hftd_pkg and the assertion macro header
module hftd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                resp_byte,
    input  logic                      frame_start,
    input  hftd_pkg::hftd_qstat_t     qstat,
    output hftd_pkg::hftd_push_t      push
);
    import hftd_pkg::*;
    `include "humidity_temp_frame_decoder_core_macros.svh"

    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        temp_fail_reg, temp_fail_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic [15:0] humid_word_reg, humid_word_next;
    logic [2:0]  pos_eff;
    logic        accept;
    logic [1:0]  frame_status;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;
    assign pos_eff  = (frame_start || (pos_reg > POS_H_CRC)) ? POS_T_MSB : pos_reg;

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        temp_fail_next  = temp_fail_reg;
        temp_word_next  = temp_word_reg;
        humid_word_next = humid_word_reg;
        if (accept)
        begin
            case (pos_eff)
                POS_T_MSB:
                begin
                    crc_next       = hftd_crc8(CRC_INIT, resp_byte);
                    temp_word_next = {resp_byte, 8'h00};
                    temp_fail_next = 1'b0;
                    pos_next       = POS_T_LSB;
                end
                POS_T_LSB:
                begin
                    crc_next       = hftd_crc8(crc_reg, resp_byte);
                    temp_word_next = {temp_word_reg[15:8], resp_byte};
                    pos_next       = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_fail_next = (crc_reg != resp_byte);
                    crc_next       = CRC_INIT;
                    pos_next       = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    crc_next        = hftd_crc8(CRC_INIT, resp_byte);
                    humid_word_next = {resp_byte, 8'h00};
                    pos_next        = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    crc_next        = hftd_crc8(crc_reg, resp_byte);
                    humid_word_next = {humid_word_reg[15:8], resp_byte};
                    pos_next        = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_T_MSB;
                end
                default:
                begin
                    pos_next = POS_T_MSB;
                end
            endcase
        end
    end

    // temperature failure outranks humidity failure
    always_comb
    begin
        if (temp_fail_reg)
        begin
            frame_status = ST_TEMP_CRC;
        end
        else if (crc_reg != resp_byte)
        begin
            frame_status = ST_HUMID_CRC;
        end
        else
        begin
            frame_status = ST_OK;
        end
    end

    assign push.valid            = accept && (pos_eff == POS_H_CRC);
    assign push.frame.temp_word  = temp_word_reg;
    assign push.frame.humid_word = humid_word_reg;
    assign push.frame.status     = frame_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_MSB;
            crc_reg       <= CRC_INIT;
            temp_fail_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_fail_reg <= temp_fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_word_reg  <= temp_word_next;
        humid_word_reg <= humid_word_next;
    end

    `HFTD_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= POS_H_CRC)
    `HFTD_ASSERT_NEXT(a_pos_wrap, push.valid, pos_reg == POS_T_MSB)

endmodule

// ===== src/hftd_fifo.sv =====
// short request queue between the front end and the back end
// depends on hftd_pkg and the assertion macro header
module hftd_fifo #(
    parameter int DEPTH = hftd_pkg::HFTD_FIFO_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hftd_pkg::hftd_push_t      push,
    input  logic                      pop,
    output hftd_pkg::hftd_frame_t     rd_frame,
    output hftd_pkg::hftd_qstat_t     qstat
);
    import hftd_pkg::*;
    `include "humidity_temp_frame_decoder_core_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hftd_frame_t   mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;

    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push.valid && !qstat.full;
    assign rd_frame    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.frame;
        end
    end

    `HFTD_ASSERT_NOW(a_no_overflow, push.valid, !qstat.full)
    `HFTD_ASSERT_NOW(a_no_underflow, pop, count_reg != '0)

endmodule

// ===== src/hftd_back.sv =====
// back end: scaling multiplies and the registered result stage
// depends on hftd_pkg and the assertion macro header
module hftd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hftd_pkg::hftd_qstat_t     qstat,
    input  hftd_pkg::hftd_frame_t     rd_frame,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [17:0]        temp_milli_c,
    output logic [16:0]               humid_milli_pct,
    output logic [1:0]                status
);
    import hftd_pkg::*;
    `include "humidity_temp_frame_decoder_core_macros.svh"

    logic        s1_valid_reg;
    logic [30:0] t_prod_reg;
    logic [29:0] h_prod_reg;
    logic [1:0]  s1_status_reg;
    logic        out_valid_reg;
    logic [17:0] temp_reg, temp_next;
    logic [16:0] humid_reg, humid_next;
    logic [1:0]  status_reg;
    logic        advance;
    logic        s1_load;
    logic [18:0] temp_diff;

    assign advance = !out_valid_reg || !out_stall;
    assign s1_load = !s1_valid_reg || advance;
    assign pop     = s1_load && !qstat.empty;

    // drop the fraction, then remove the offset
    assign temp_diff = {1'b0, t_prod_reg[30:FRAC_BITS]} - 19'(TEMP_OFFSET);

    always_comb
    begin
        if (s1_status_reg == ST_OK)
        begin
            temp_next  = temp_diff[17:0];
            humid_next = h_prod_reg[29:FRAC_BITS];
        end
        else
        begin
            temp_next  = '0;
            humid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= !qstat.empty;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            t_prod_reg    <= 31'(TEMP_SCALE) * 31'(rd_frame.temp_word);
            h_prod_reg    <= 30'(HUMID_SCALE) * 30'(rd_frame.humid_word);
            s1_status_reg <= rd_frame.status;
        end
        if (advance && s1_valid_reg)
        begin
            temp_reg   <= temp_next;
            humid_reg  <= humid_next;
            status_reg <= s1_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign temp_milli_c    = $signed(temp_reg);
    assign humid_milli_pct = humid_reg;
    assign status          = status_reg;

    `HFTD_ASSERT_NOW(a_err_zero, out_valid_reg && (status_reg != ST_OK),
                     (temp_reg == '0) && (humid_reg == '0))

endmodule

// ===== bench/tb.sv =====
// self-checking bench for humidity_temp_frame_decoder_core: sends response bytes,
// predicts each decoded reading and checks every result request against it
// depends on hftd_pkg and humidity_temp_frame_decoder_core
module tb;

    import hftd_pkg::*;

    // generous ceiling for about 2.1k byte requests
    localparam int unsigned CYCLE_LIMIT = 400000;
    // settling time after the last result
    localparam int SETTLE_CYCLES = 8;

    // one decoded reading as it should leave the block
    typedef struct {
        logic signed [17:0] temp;
        logic [16:0]        humid;
        logic [1:0]         st;
    } reading_t;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         resp_byte = 8'h00;
    logic               frame_start = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [17:0] temp_milli_c;
    logic [16:0]        humid_milli_pct;
    logic [1:0]         status;

    // idle percentages for the sending and receiving sides
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int          mismatch_count = 0;
    int unsigned cycle_count = 0;

    // readings predicted but not yet seen at the output, oldest first
    reading_t pending_readings[$];

    // predictor state, mirrors the frame decoder's own registers
    logic [2:0]  frame_pos = 3'd0;
    logic [7:0]  crc_acc = CRC_INIT;
    logic [15:0] temp_raw = 16'h0000;
    logic [15:0] humid_raw = 16'h0000;
    logic        temp_bad = 1'b0;

    humidity_temp_frame_decoder_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .resp_byte       (resp_byte),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .temp_milli_c    (temp_milli_c),
        .humid_milli_pct (humid_milli_pct),
        .status          (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // crc-8 worked bit-serially: feedback is the top crc bit xor the data bit
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // advance the predictor by one accepted byte; has_reading marks the sixth byte
    function automatic void decode_byte(input logic [7:0] b, input logic fs,
                                        output logic has_reading, output reading_t r);
        logic [2:0]  pos;
        logic [31:0] t32;
        logic [31:0] h32;
        pos = fs ? 3'd0 : frame_pos;
        if (pos > 3'd5)
        begin
            pos = 3'd0;
        end
        has_reading = 1'b0;
        r.temp = '0;
        r.humid = '0;
        r.st = ST_OK;
        case (pos)
            3'd0:
            begin
                crc_acc = crc8_feed(CRC_INIT, b);
                temp_raw = {b, 8'h00};
                temp_bad = 1'b0;
                frame_pos = 3'd1;
            end
            3'd1:
            begin
                crc_acc = crc8_feed(crc_acc, b);
                temp_raw[7:0] = b;
                frame_pos = 3'd2;
            end
            3'd2:
            begin
                temp_bad = (crc_acc != b);
                crc_acc = CRC_INIT;
                frame_pos = 3'd3;
            end
            3'd3:
            begin
                crc_acc = crc8_feed(CRC_INIT, b);
                humid_raw = {b, 8'h00};
                frame_pos = 3'd4;
            end
            3'd4:
            begin
                crc_acc = crc8_feed(crc_acc, b);
                humid_raw[7:0] = b;
                frame_pos = 3'd5;
            end
            default:
            begin
                has_reading = 1'b1;
                if (temp_bad)
                begin
                    r.st = ST_TEMP_CRC;
                end
                else if (crc_acc != b)
                begin
                    r.st = ST_HUMID_CRC;
                end
                else
                begin
                    // 32-bit unsigned maths, wrap to the port widths
                    t32 = ((32'(TEMP_SCALE) * 32'(temp_raw)) >> FRAC_BITS)
                          - 32'(TEMP_OFFSET);
                    h32 = (32'(HUMID_SCALE) * 32'(humid_raw)) >> FRAC_BITS;
                    r.temp = t32[17:0];
                    r.humid = h32[16:0];
                end
                crc_acc = CRC_INIT;
                frame_pos = 3'd0;
            end
        endcase
    endfunction

    // present one byte request, hold it through any stall, predict on acceptance
    task automatic send_byte(input logic [7:0] b, input logic fs);
        logic     has_reading;
        reading_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        resp_byte <= b;
        frame_start <= fs;
        // in_stall is stable between the falling and the next rising edge
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        decode_byte(b, fs, has_reading, r);
        if (has_reading)
        begin
            pending_readings.push_back(r);
        end
    endtask

    // six-byte frame with correct crcs, each optionally spoilt by an xor mask
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                              input logic [7:0] tmask, input logic [7:0] hmask,
                              input logic fs);
        logic [7:0] tcrc;
        logic [7:0] hcrc;
        tcrc = crc8_feed(crc8_feed(CRC_INIT, tw[15:8]), tw[7:0]) ^ tmask;
        hcrc = crc8_feed(crc8_feed(CRC_INIT, hw[15:8]), hw[7:0]) ^ hmask;
        send_byte(tw[15:8], fs);
        send_byte(tw[7:0], 1'b0);
        send_byte(tcrc, 1'b0);
        send_byte(hw[15:8], 1'b0);
        send_byte(hw[7:0], 1'b0);
        send_byte(hcrc, 1'b0);
    endtask

    // sender goes quiet until every predicted reading has come out
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_readings.size() != 0);
    endtask

    // word extremes: all-zero word with frame_start, all-ones relying on the wrap
    task automatic test_limits();
        send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1);
        send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0);
    endtask

    // both crcs wrong: temperature failure takes priority
    task automatic test_crc_mismatch();
        send_frame(16'h6A3C, 16'h8155, 8'h01, 8'h80, 1'b1);
    endtask

    // partial frame dropped by a fresh frame_start, then a humidity crc failure
    task automatic test_restart();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_frame(16'h1234, 16'hA5C3, 8'h00, 8'h5A, 1'b1);
    endtask

    // mostly well-formed frames with random words, some bad crcs, some noise
    task automatic test_random_traffic(input int n_items);
        int          sent;
        int          len;
        logic [15:0] tw;
        logic [15:0] hw;
        logic [7:0]  tmask;
        logic [7:0]  hmask;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                tw = ($urandom_range(99) < 8) ? {16{1'($urandom_range(1))}} : 16'($urandom);
                hw = ($urandom_range(99) < 8) ? {16{1'($urandom_range(1))}} : 16'($urandom);
                tmask = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
                hmask = ($urandom_range(99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_frame(tw, hw, tmask, hmask, $urandom_range(99) < 80);
                sent += 6;
            end
            else
            begin
                // broken sequence: stray bytes, restarts at random points
                len = $urandom_range(1, 8);
                repeat (len)
                begin
                    send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
                end
                sent += len;
            end
            if ($urandom_range(99) < 3)
            begin
                hold_until_drained();
            end
        end
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker: outputs are stable at the falling edge before the taking edge
    always @(negedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result request: temp %0d humid %0d status %0d",
                       temp_milli_c, humid_milli_pct, status);
                mismatch_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (temp_milli_c !== want.temp)
                begin
                    $error("temp_milli_c: expected %0d, actual %0d", want.temp, temp_milli_c);
                    mismatch_count++;
                end
                if (humid_milli_pct !== want.humid)
                begin
                    $error("humid_milli_pct: expected %0d, actual %0d",
                           want.humid, humid_milli_pct);
                    mismatch_count++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[humidity_temp_frame_decoder_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles a third of the time, receiver three quarters
        send_idle_pct = 33;
        recv_idle_pct = 75;
        test_limits();
        test_crc_mismatch();
        test_restart();
        hold_until_drained();
        test_random_traffic(700);
        hold_until_drained();

        // roles swapped: slow sender, mostly ready receiver
        send_idle_pct = 75;
        recv_idle_pct = 33;
        test_random_traffic(700);
        hold_until_drained();

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(650);
        hold_until_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_readings.size() == 0)
        begin
            $display("[humidity_temp_frame_decoder_core] OK");
        end
        else
        begin
            $display("[humidity_temp_frame_decoder_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/hftd_pkg.sv
src/hftd_front.sv
src/hftd_fifo.sv
src/hftd_back.sv
src/humidity_temp_frame_decoder_core.sv
bench/tb.sv
